// ----- rtl/tvcp_pkg.sv -----
// Shared constants and types for the tag/value command parser.
// Used by tvcp_parse, tvcp_act and tag_value_command_parser_core; no dependencies.
package tvcp_pkg;

    localparam int VALUE_BITS_DEF = 16;
    localparam int VALUE_BITS_MIN = 8;
    localparam int VALUE_BITS_MAX = 32;

    localparam int CFG_BITS = 16;
    localparam int OUT_VALUE_BITS = 16;
    localparam int TAG_BITS = 5;
    localparam int TDATA_OUT_BITS = 48;

    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic signed [TAG_BITS-1:0] TAG_NONE  = -5'sd1;
    localparam logic signed [TAG_BITS-1:0] TAG_REV   = 5'sd0;
    localparam logic signed [TAG_BITS-1:0] TAG_FWD   = 5'sd1;
    localparam logic signed [TAG_BITS-1:0] TAG_SERVO = 5'sd4;
    localparam logic signed [TAG_BITS-1:0] TAG_SPK   = 5'sd6;

    localparam logic [0:0] CFG_IDX_THRESHOLD  = 1'b0;
    localparam logic [0:0] CFG_IDX_FULL_SCALE = 1'b1;

    localparam logic [CFG_BITS-1:0] THRESHOLD_RESET  = 16'd150;
    localparam logic [CFG_BITS-1:0] FULL_SCALE_RESET = 16'd180;
    localparam logic [OUT_VALUE_BITS-1:0] SERVO_RESET = 16'd90;
    localparam logic [OUT_VALUE_BITS-1:0] OUT_VALUE_MAX = 16'hFFFF;

    // Frame close event from the parser to the actuator stage
    typedef struct packed {
        logic                       close;
        logic signed [TAG_BITS-1:0] tag;
    } tvcp_close_t;

    typedef struct packed {
        logic signed [TAG_BITS-1:0]  frame_tag;
        logic [OUT_VALUE_BITS-1:0]   frame_value;
        logic                        motor_enable;
        logic                        motor_reverse;
        logic [OUT_VALUE_BITS-1:0]   servo_position;
        logic                        speaker_on;
        logic                        tag_lamp;
        logic                        value_high_lamp;
    } tvcp_result_t;

endpackage

// ----- rtl/tvcp_parse.sv -----
// Frame parser: tag/value phase, skip phase, tag and saturating value accumulator.
// Depends on tvcp_pkg.
module tvcp_parse #(
    parameter int VALUE_BITS = tvcp_pkg::VALUE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    byte_fire,
    input  logic [7:0]              rx_byte,
    output tvcp_pkg::tvcp_close_t   close_ev,
    output logic [VALUE_BITS-1:0]   frame_value
);

    localparam int NB = VALUE_BITS + 4;

    logic                                   reading_tag_reg, reading_tag_next;
    logic                                   skipping_reg, skipping_next;
    logic signed [tvcp_pkg::TAG_BITS-1:0]   tag_reg, tag_next;
    logic [VALUE_BITS-1:0]                  accum_reg, accum_next;

    logic           is_bang;
    logic           is_comma;
    logic           is_digit;
    logic [3:0]     digit;
    logic [NB-1:0]  acc_ext;
    logic [NB-1:0]  acc_mul;

    assign is_bang  = (rx_byte == tvcp_pkg::CH_BANG);
    assign is_comma = (rx_byte == tvcp_pkg::CH_COMMA);
    assign is_digit = (rx_byte >= tvcp_pkg::CH_ZERO) && (rx_byte <= tvcp_pkg::CH_NINE);
    assign digit    = 4'(rx_byte - tvcp_pkg::CH_ZERO);

    // value * 10 + digit, by shifts
    assign acc_ext = NB'(accum_reg);
    assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + NB'(digit);

    assign close_ev.close = byte_fire && is_bang;
    assign close_ev.tag   = tag_reg;
    assign frame_value    = accum_reg;

    always_comb
    begin
        reading_tag_next = reading_tag_reg;
        skipping_next    = skipping_reg;
        tag_next         = tag_reg;
        accum_next       = accum_reg;
        if (byte_fire)
        begin
            if (is_bang)
            begin
                reading_tag_next = 1'b1;
                skipping_next    = 1'b0;
                tag_next         = tvcp_pkg::TAG_NONE;
                accum_next       = '0;
            end
            else if (!skipping_reg)
            begin
                if (is_comma)
                begin
                    reading_tag_next = 1'b0;
                end
                else if (!is_digit)
                begin
                    skipping_next = 1'b1;
                end
                else if (reading_tag_reg)
                begin
                    tag_next = $signed({1'b0, digit});
                end
                else
                begin
                    // saturate when any bit spills over the top
                    if (acc_mul[NB-1:VALUE_BITS] != '0)
                        accum_next = '1;
                    else
                        accum_next = acc_mul[VALUE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_tag_reg <= 1'b1;
            skipping_reg    <= 1'b0;
            tag_reg         <= tvcp_pkg::TAG_NONE;
            accum_reg       <= '0;
        end
        else
        begin
            reading_tag_reg <= reading_tag_next;
            skipping_reg    <= skipping_next;
            tag_reg         <= tag_next;
            accum_reg       <= accum_next;
        end
    end

endmodule

// ----- rtl/tvcp_act.sv -----
// Actuator state update on frame close, and the result register.
// Depends on tvcp_pkg.
module tvcp_act #(
    parameter int VALUE_BITS = tvcp_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tvcp_pkg::tvcp_close_t           close_ev,
    input  logic [VALUE_BITS-1:0]           frame_value,
    input  logic [tvcp_pkg::CFG_BITS-1:0]   threshold,
    input  logic [tvcp_pkg::CFG_BITS-1:0]   full_scale,
    input  logic                            res_ready,
    output logic                            res_valid,
    output logic                            slot_free,
    output tvcp_pkg::tvcp_result_t          result
);

    localparam int CW = (VALUE_BITS > tvcp_pkg::CFG_BITS) ? VALUE_BITS : tvcp_pkg::CFG_BITS;

    logic                                   drive_en_reg, drive_en_next;
    logic                                   drive_rev_reg, drive_rev_next;
    logic [tvcp_pkg::OUT_VALUE_BITS-1:0]    servo_reg, servo_next;
    logic                                   tone_reg, tone_next;
    logic                                   tag_lamp_reg, tag_lamp_next;
    logic                                   high_reg, high_next;
    logic                                   res_valid_reg;
    tvcp_pkg::tvcp_result_t                 res_reg, res_next;

    logic [CW-1:0]                          vx;
    logic                                   v_one;
    logic                                   v_zero;
    logic [tvcp_pkg::OUT_VALUE_BITS-1:0]    v_sat;

    assign vx     = CW'(frame_value);
    assign v_one  = (vx == CW'(1));
    assign v_zero = (vx == '0);
    assign v_sat  = (vx > CW'(tvcp_pkg::OUT_VALUE_MAX)) ? tvcp_pkg::OUT_VALUE_MAX
                                                        : vx[tvcp_pkg::OUT_VALUE_BITS-1:0];

    assign slot_free = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign result    = res_reg;

    always_comb
    begin
        drive_en_next  = drive_en_reg;
        drive_rev_next = drive_rev_reg;
        servo_next     = servo_reg;
        tone_next      = tone_reg;
        tag_lamp_next  = tag_lamp_reg;
        high_next      = high_reg;
        if (close_ev.tag == tvcp_pkg::TAG_FWD)
        begin
            tag_lamp_next  = 1'b1;
            drive_en_next  = v_one;
            drive_rev_next = 1'b0;
        end
        else if (close_ev.tag == tvcp_pkg::TAG_REV)
        begin
            drive_en_next  = v_one;
            drive_rev_next = 1'b1;
        end
        else if (close_ev.tag == tvcp_pkg::TAG_SERVO && !v_zero)
        begin
            // clamp to full scale
            if (vx > CW'(full_scale))
                servo_next = full_scale;
            else
                servo_next = vx[tvcp_pkg::OUT_VALUE_BITS-1:0];
        end
        else if (close_ev.tag == tvcp_pkg::TAG_SPK)
        begin
            tone_next = v_one;
        end
        else
        begin
            tag_lamp_next = 1'b0;
        end
        high_next = (vx > CW'(threshold));

        res_next.frame_tag       = close_ev.tag;
        res_next.frame_value     = v_sat;
        res_next.motor_enable    = drive_en_next;
        res_next.motor_reverse   = drive_rev_next;
        res_next.servo_position  = servo_next;
        res_next.speaker_on      = tone_next;
        res_next.tag_lamp        = tag_lamp_next;
        res_next.value_high_lamp = high_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_en_reg  <= 1'b0;
            drive_rev_reg <= 1'b0;
            servo_reg     <= tvcp_pkg::SERVO_RESET;
            tone_reg      <= 1'b0;
            tag_lamp_reg  <= 1'b0;
            high_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (close_ev.close)
            begin
                drive_en_reg  <= drive_en_next;
                drive_rev_reg <= drive_rev_next;
                servo_reg     <= servo_next;
                tone_reg      <= tone_next;
                tag_lamp_reg  <= tag_lamp_next;
                high_reg      <= high_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded only when a frame closes
    always_ff @(posedge clk)
    begin
        if (close_ev.close)
            res_reg <= res_next;
    end

endmodule

// ----- rtl/tag_value_command_parser_core.sv -----
// Tag/value command parser: top level with input register, config registers and stream ports.
// Depends on tvcp_pkg, tvcp_parse and tvcp_act.
// Order: an accepted '!' passes the input register and then the result register before m_tvalid rises.
// Throughput: one byte per cycle; a '!' waits in the input register only while the
// result register holds an untaken result.
// Reset (rst_n low, asynchronous): tag phase, no tag, value zero, servo 90, all lamps off.
module tag_value_command_parser_core #(
    parameter int VALUE_BITS = tvcp_pkg::VALUE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [7:0]                              s_tdata,    // [7:0] rx_byte
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // [4:0] frame_tag, [20:5] frame_value, [21] motor_enable, [22] motor_reverse,
    // [38:23] servo_position, [39] speaker_on, [40] tag_lamp, [41] value_high_lamp,
    // [47:42] zero
    output logic [tvcp_pkg::TDATA_OUT_BITS-1:0]     m_tdata,
    input  logic                                    cfg_we,
    input  logic [0:0]                              cfg_addr,
    input  logic [tvcp_pkg::CFG_BITS-1:0]           cfg_wdata
);

    logic                               s1_valid_reg;
    logic [7:0]                         s1_byte_reg;
    logic                               s1_fire;
    logic                               slot_free;
    logic [tvcp_pkg::CFG_BITS-1:0]      threshold_reg;
    logic [tvcp_pkg::CFG_BITS-1:0]      full_scale_reg;
    tvcp_pkg::tvcp_close_t              close_ev;
    logic [VALUE_BITS-1:0]              frame_value;
    tvcp_pkg::tvcp_result_t             result;

    // hold a '!' until the result register can take it
    assign s1_fire  = s1_valid_reg && ((s1_byte_reg != tvcp_pkg::CH_BANG) || slot_free);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            s1_byte_reg <= s_tdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= tvcp_pkg::THRESHOLD_RESET;
            full_scale_reg <= tvcp_pkg::FULL_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                tvcp_pkg::CFG_IDX_THRESHOLD:  threshold_reg  <= cfg_wdata;
                tvcp_pkg::CFG_IDX_FULL_SCALE: full_scale_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    tvcp_parse #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_fire   (s1_fire),
        .rx_byte     (s1_byte_reg),
        .close_ev    (close_ev),
        .frame_value (frame_value)
    );

    tvcp_act #(
        .VALUE_BITS (VALUE_BITS)
    ) u_act (
        .clk         (clk),
        .rst_n       (rst_n),
        .close_ev    (close_ev),
        .frame_value (frame_value),
        .threshold   (threshold_reg),
        .full_scale  (full_scale_reg),
        .res_ready   (m_tready),
        .res_valid   (m_tvalid),
        .slot_free   (slot_free),
        .result      (result)
    );

    assign m_tdata = {6'b0,
                      result.value_high_lamp,
                      result.tag_lamp,
                      result.speaker_on,
                      result.servo_position,
                      result.motor_reverse,
                      result.motor_enable,
                      result.frame_value,
                      result.frame_tag};

`ifndef SYNTHESIS
    a_rise_after_bang: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s1_valid_reg && (s1_byte_reg == tvcp_pkg::CH_BANG)))
        else $error("result raised without a closing byte");

    a_bang_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && s1_valid_reg && (s1_byte_reg == tvcp_pkg::CH_BANG))
        |-> !s_tready)
        else $error("closing byte accepted over a stalled result");

    a_ready_low_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> s1_valid_reg)
        else $error("input stalled with an empty input register");
`endif

endmodule
